// ----- sv/mmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

  localparam int TableEntries = 32;
  localparam int DefaultQueryInterval = 10;

  // command codes
  localparam logic [2:0] CMD_JOIN  = 3'd0;
  localparam logic [2:0] CMD_LEAVE = 3'd1;
  localparam logic [2:0] CMD_QUERY = 3'd2;
  localparam logic [2:0] CMD_ALLOW = 3'd3;
  localparam logic [2:0] CMD_DENY  = 3'd4;
  localparam logic [2:0] CMD_SWEEP = 3'd5;

  // policy classes
  localparam logic [1:0] CLS_WHITE = 2'd0;
  localparam logic [1:0] CLS_GREY  = 2'd1;

  // network requests
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // configuration register indexes
  localparam logic CFG_PROFILE  = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] group;
    logic [1:0]  policy_class;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        member;
    logic [1:0]  request;
    logic [31:0] request_group;
    logic        removed;
    logic        table_full;
    logic        last;
  } out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  cls;
    logic [31:0] group;
    logic [31:0] now;
    logic        profile;
    logic [15:0] qi;
    logic        apply;
    logic        any_hit;
  } ctl_t;

  // passed from cell to cell along the row
  typedef struct packed {
    logic        hit;
    logic        free;
    logic        member;
    logic        expired;
    logic        grey;
    logic [31:0] group;
  } chain_t;

endpackage

`default_nettype wire

// ----- sv/mmt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmt_cell #(
  parameter int IW = 5,
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mmt_pkg::ctl_t   ctl,
  input  wire logic [IW-1:0]   sweep_idx,
  input  wire mmt_pkg::chain_t chain_in,
  output mmt_pkg::chain_t      chain_out
);

  logic        valid_r, valid_nxt;
  logic [31:0] group_r, group_nxt;
  logic [31:0] time_r, time_nxt;
  logic        pinned_r, pinned_nxt;
  logic        grey_r, grey_nxt;

  logic [31:0] age;
  logic        hit, first_hit, first_free, fresh, sel, expired;

  // match and age this entry
  always_comb begin
    age        = ctl.now - time_r;
    hit        = valid_r && (group_r == ctl.group);
    first_hit  = hit && !chain_in.hit;
    first_free = !valid_r && !chain_in.free;
    fresh      = pinned_r || (age <= {16'd0, ctl.qi});
    sel        = (sweep_idx == IW'(IDX));
    expired    = ctl.profile && valid_r && !pinned_r && sel &&
                 (age > {15'd0, ctl.qi, 1'b0});
  end

  // hand the running results to the next cell
  always_comb begin
    chain_out.hit     = chain_in.hit | hit;
    chain_out.free    = chain_in.free | !valid_r;
    chain_out.member  = chain_in.member | (first_hit & fresh);
    chain_out.expired = chain_in.expired | expired;
    chain_out.grey    = chain_in.grey | (expired & grey_r);
    chain_out.group   = chain_in.group | (expired ? group_r : 32'd0);
  end

  // update the entry for the current command
  always_comb begin
    valid_nxt  = valid_r;
    group_nxt  = group_r;
    time_nxt   = time_r;
    pinned_nxt = pinned_r;
    grey_nxt   = grey_r;
    if (ctl.apply) begin
      unique case (ctl.op)
        mmt_pkg::CMD_JOIN: begin
          if (ctl.profile) begin
            if (ctl.any_hit) begin
              if (first_hit && !pinned_r) time_nxt = ctl.now;
            end else if (ctl.cls == mmt_pkg::CLS_WHITE && first_free) begin
              valid_nxt  = 1'b1;
              group_nxt  = ctl.group;
              time_nxt   = ctl.now;
              pinned_nxt = 1'b0;
              grey_nxt   = 1'b0;
            end
          end
        end
        mmt_pkg::CMD_LEAVE: begin
          if (ctl.profile && first_hit) valid_nxt = 1'b0;
        end
        mmt_pkg::CMD_ALLOW: begin
          if (ctl.any_hit) begin
            if (first_hit) pinned_nxt = 1'b1;
          end else if (first_free) begin
            valid_nxt  = 1'b1;
            group_nxt  = ctl.group;
            time_nxt   = ctl.now;
            pinned_nxt = 1'b1;
            grey_nxt   = (ctl.cls == mmt_pkg::CLS_GREY);
          end
        end
        mmt_pkg::CMD_DENY: begin
          if (first_hit) valid_nxt = 1'b0;
        end
        mmt_pkg::CMD_SWEEP: begin
          if (expired) valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    group_r  <= group_nxt;
    time_r   <= time_nxt;
    pinned_r <= pinned_nxt;
    grey_r   <= grey_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/multicast_membership_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Lookup: join, leave, query, allow and deny are held in item_r once accepted, looked
//   up across the row of entry cells in ST_LOOK, and their result registered in out_r.
// Flow: one transaction at a time; a new one is taken only after the last result is taken.
//   A sweep walks one cell per cycle, pausing while a removal report waits for out_ready.
// Reset (rst_n low, synchronous): all entries invalid, profile_present 0,
//   membership lifetime 10 ticks, no result pending.

module multicast_membership_table_unit #(
  parameter int TABLE_ENTRIES = mmt_pkg::TableEntries
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mmt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mmt_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_LOOK, ST_OUT, ST_SWEEP, ST_SOUT} state_t;

  state_t          state_r;
  mmt_pkg::in_t    item_r;
  mmt_pkg::out_t   out_r;
  logic            out_valid_r;
  logic [IW-1:0]   idx_r;
  logic            end_r;
  logic            profile_r;
  logic [15:0]     qi_r;

  mmt_pkg::ctl_t   ctl;
  mmt_pkg::chain_t chain [TABLE_ENTRIES+1];
  mmt_pkg::chain_t tail;
  mmt_pkg::out_t   look_res;
  mmt_pkg::out_t   sweep_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign chain[0]  = '0;
  assign tail      = chain[TABLE_ENTRIES];

  // broadcast the held transaction to the cells
  always_comb begin
    ctl.op       = item_r.command;
    ctl.cls      = item_r.policy_class;
    ctl.group    = item_r.group;
    ctl.now      = item_r.now;
    ctl.profile  = profile_r;
    ctl.qi       = qi_r;
    ctl.any_hit  = tail.hit;
    ctl.apply    = (state_r == ST_LOOK && item_r.command != mmt_pkg::CMD_SWEEP) ||
                   (state_r == ST_SWEEP && !end_r);
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      mmt_cell #(.IW(IW), .IDX(gi)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sweep_idx (idx_r),
        .chain_in  (chain[gi]),
        .chain_out (chain[gi+1])
      );
    end
  endgenerate

  // form the single result of a lookup command
  always_comb begin
    look_res      = '0;
    look_res.last = 1'b1;
    unique case (item_r.command)
      mmt_pkg::CMD_JOIN: begin
        if (profile_r && !tail.hit) begin
          if (item_r.policy_class == mmt_pkg::CLS_WHITE) begin
            look_res.accepted   = tail.free;
            look_res.table_full = !tail.free;
          end else if (item_r.policy_class == mmt_pkg::CLS_GREY) begin
            look_res.request       = mmt_pkg::REQ_ADD;
            look_res.request_group = item_r.group;
          end
        end
      end
      mmt_pkg::CMD_LEAVE: begin
        if (profile_r && tail.hit) begin
          look_res.accepted      = 1'b1;
          look_res.request_group = item_r.group;
          look_res.request       = (item_r.policy_class == mmt_pkg::CLS_GREY) ?
                                   mmt_pkg::REQ_DELETE : mmt_pkg::REQ_NONE;
        end
      end
      mmt_pkg::CMD_QUERY: look_res.member = tail.member;
      mmt_pkg::CMD_ALLOW: look_res.table_full = !tail.hit && !tail.free;
      default: ;
    endcase
  end

  // form a sweep removal report, or the closing result once the walk is done
  always_comb begin
    sweep_res = '0;
    if (end_r) begin
      sweep_res.last = 1'b1;
    end else begin
      sweep_res.removed       = 1'b1;
      sweep_res.request_group = tail.group;
      sweep_res.request       = tail.grey ? mmt_pkg::REQ_DELETE : mmt_pkg::REQ_NONE;
    end
  end

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= 1'b0;
      qi_r      <= 16'(mmt_pkg::DefaultQueryInterval);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmt_pkg::CFG_PROFILE:  profile_r <= cfg_data[0];
        mmt_pkg::CFG_INTERVAL: qi_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequence lookups, the sweep walk and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      end_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (item_r.command == mmt_pkg::CMD_SWEEP) begin
            idx_r   <= '0;
            end_r   <= !profile_r;
            state_r <= ST_SWEEP;
          end else begin
            out_r       <= look_res;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (end_r) begin
            out_r       <= sweep_res;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end else begin
            if (tail.expired) begin
              out_r       <= sweep_res;
              out_valid_r <= 1'b1;
              state_r     <= ST_SOUT;
            end
            if (idx_r == IW'(TABLE_ENTRIES - 1)) end_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end
        end
        ST_SOUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_SWEEP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mmt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmt_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire mmt_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // take one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

  // only sweep removals leave a transaction open
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last || out_data.removed)
    else $error("non-final result without removal");

  // removal reports carry no other flags
  a_removed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.removed |->
      !out_data.accepted && !out_data.member && !out_data.table_full && !out_data.last)
    else $error("removal result with stray flags");

  // no result while ready to take input
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("result pending while ready");

endmodule

bind multicast_membership_table_unit mmt_checker u_mmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- dv/multicast_membership_table_unit_tb.sv -----
`timescale 1ns / 1ps

module multicast_membership_table_unit_tb;
  import mmt_pkg::*;

  localparam int NumEntries = TableEntries;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the table and registers
  logic model_profile;
  logic [15:0] model_qi;
  logic tbl_valid[NumEntries];
  logic [31:0] tbl_group[NumEntries];
  logic [31:0] tbl_time[NumEntries];
  logic tbl_pinned[NumEntries];
  logic tbl_grey[NumEntries];

  out_t expected_results[$];
  int error_count;
  logic hold_off;

  // recently used groups, so random traffic hits existing entries
  logic [31:0] group_pool[8];

  multicast_membership_table_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic out_t blank_result();
    out_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int lookup_group(logic [31:0] g);
    for (int i = 0; i < NumEntries; i++)
      if (tbl_valid[i] && tbl_group[i] == g) return i;
    return -1;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NumEntries; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  // compute the results of one transaction and advance the table copy
  task automatic predict_membership(in_t t);
    out_t r;
    int idx;
    logic [31:0] age;
    r = blank_result();
    idx = lookup_group(t.group);
    case (t.command)
      CMD_JOIN: begin
        if (model_profile) begin
          if (idx >= 0) begin
            if (!tbl_pinned[idx]) tbl_time[idx] = t.now;
          end else if (t.policy_class == CLS_WHITE) begin
            idx = lowest_free();
            if (idx < 0) begin
              r.table_full = 1'b1;
            end else begin
              tbl_valid[idx] = 1'b1;
              tbl_group[idx] = t.group;
              tbl_time[idx] = t.now;
              tbl_pinned[idx] = 1'b0;
              tbl_grey[idx] = 1'b0;
              r.accepted = 1'b1;
            end
          end else if (t.policy_class == CLS_GREY) begin
            r.request = REQ_ADD;
            r.request_group = t.group;
          end
        end
      end
      CMD_LEAVE: begin
        if (model_profile && idx >= 0) begin
          tbl_valid[idx] = 1'b0;
          r.accepted = 1'b1;
          r.request_group = t.group;
          r.request = (t.policy_class == CLS_GREY) ? REQ_DELETE : REQ_NONE;
        end
      end
      CMD_QUERY: begin
        if (idx >= 0) begin
          age = t.now - tbl_time[idx];
          r.member = tbl_pinned[idx] || (age <= {16'd0, model_qi});
        end
      end
      CMD_ALLOW: begin
        if (idx >= 0) begin
          tbl_pinned[idx] = 1'b1;
        end else begin
          idx = lowest_free();
          if (idx < 0) begin
            r.table_full = 1'b1;
          end else begin
            tbl_valid[idx] = 1'b1;
            tbl_group[idx] = t.group;
            tbl_time[idx] = t.now;
            tbl_pinned[idx] = 1'b1;
            tbl_grey[idx] = (t.policy_class == CLS_GREY);
          end
        end
      end
      CMD_DENY: begin
        if (idx >= 0) tbl_valid[idx] = 1'b0;
      end
      CMD_SWEEP: begin
        if (model_profile) begin
          for (int i = 0; i < NumEntries; i++) begin
            age = t.now - tbl_time[i];
            if (tbl_valid[i] && !tbl_pinned[i] && {1'b0, age} > {16'd0, model_qi, 1'b0}) begin
              out_t rm;
              rm = '0;
              rm.removed = 1'b1;
              rm.request_group = tbl_group[i];
              rm.request = tbl_grey[i] ? REQ_DELETE : REQ_NONE;
              tbl_valid[i] = 1'b0;
              expected_results.push_back(rm);
            end
          end
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // offer one transaction and wait for its acceptance
  task automatic send_item(in_t t);
    in_valid = 1'b1;
    in_data = t;
    do @(posedge clk); while (!in_ready);
    predict_membership(t);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random burst gaps for the sender
  int burst_left;
  task automatic send_paced(in_t t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    send_item(t);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_PROFILE) model_profile = value[0];
    else model_qi = value;
  endtask

  // drain expectations, then let the pipeline settle before a register write
  task automatic wait_idle();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (NumEntries + 8) @(negedge clk);
  endtask

  function automatic in_t make_item(logic [2:0] c, logic [31:0] g, logic [1:0] p,
                                    logic [31:0] n);
    in_t t;
    t.command = c;
    t.group = g;
    t.policy_class = p;
    t.now = n;
    return t;
  endfunction

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        out_t e;
        e = expected_results.pop_front();
        if (out_data.accepted !== e.accepted || out_data.member !== e.member ||
            out_data.request !== e.request || out_data.request_group !== e.request_group ||
            out_data.removed !== e.removed || out_data.table_full !== e.table_full ||
            out_data.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          error_count++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b1;
    else if (hold_off) out_ready <= 1'b0;
    else if (($time / 400) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    hold_off = 1'b0;
    #0;
    forever begin
      @(negedge clk);
    end
  end

  task automatic test_no_profile();
    send_item(make_item(CMD_JOIN, 32'h0, CLS_WHITE, 32'h0));
    send_item(make_item(CMD_LEAVE, 32'h0, CLS_GREY, 32'h0));
    send_item(make_item(CMD_ALLOW, 32'hFFFF_FFFF, CLS_GREY, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SWEEP, 32'h0, CLS_WHITE, 32'hFFFF_FFFF));
    send_item(make_item(CMD_QUERY, 32'hFFFF_FFFF, 2'd3, 32'h0));
    send_item(make_item(3'd6, 32'h1234, 2'd2, 32'h5));
    send_item(make_item(3'd7, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    send_item(make_item(CMD_DENY, 32'hFFFF_FFFF, CLS_WHITE, 32'h0));
  endtask

  task automatic test_directed_ops();
    send_item(make_item(CMD_JOIN, 32'hE000_0001, CLS_WHITE, 32'd100));
    send_item(make_item(CMD_JOIN, 32'hE000_0001, CLS_WHITE, 32'd105));
    send_item(make_item(CMD_JOIN, 32'hE000_0002, CLS_GREY, 32'd106));
    send_item(make_item(CMD_JOIN, 32'hE000_0003, 2'd2, 32'd106));
    send_item(make_item(CMD_JOIN, 32'hE000_0004, 2'd3, 32'd106));
    send_item(make_item(CMD_QUERY, 32'hE000_0001, CLS_WHITE, 32'd115));
    send_item(make_item(CMD_QUERY, 32'hE000_0001, CLS_WHITE, 32'd116));
    send_item(make_item(CMD_ALLOW, 32'hE000_0005, CLS_GREY, 32'd0));
    send_item(make_item(CMD_ALLOW, 32'hE000_0001, CLS_WHITE, 32'd0));
    send_item(make_item(CMD_JOIN, 32'hE000_0006, CLS_WHITE, 32'hFFFF_FFF0));
    send_item(make_item(CMD_SWEEP, 32'h0, CLS_WHITE, 32'd4));
    send_item(make_item(CMD_SWEEP, 32'h0, CLS_WHITE, 32'd200));
    send_item(make_item(CMD_LEAVE, 32'hE000_0005, CLS_GREY, 32'd0));
    send_item(make_item(CMD_LEAVE, 32'hE000_0001, CLS_WHITE, 32'd0));
    send_item(make_item(CMD_LEAVE, 32'hE000_0009, CLS_GREY, 32'd0));
  endtask

  // fill the table to force the full flag
  task automatic test_table_full();
    for (int i = 0; i <= NumEntries; i++)
      send_paced(make_item(CMD_ALLOW, 32'hEF00_0000 + i, CLS_GREY, 32'd7));
    send_item(make_item(CMD_JOIN, 32'hEF10_0000, CLS_WHITE, 32'd7));
    for (int i = 0; i < NumEntries; i++)
      send_paced(make_item(CMD_DENY, 32'hEF00_0000 + i, CLS_WHITE, 32'd7));
  endtask

  // hold the receiver off while queries pile up behind it
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_item(make_item(CMD_QUERY, group_pool[i % 8], CLS_WHITE, $urandom()));
    join
  endtask

  task automatic test_random(int count, logic [31:0] base_time);
    in_t t;
    logic [31:0] clock_now;
    clock_now = base_time;
    for (int i = 0; i < count; i++) begin
      clock_now += $urandom_range(0, 3 * model_qi + 2);
      t.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 9) < 8) t.group = group_pool[$urandom_range(0, 7)];
      else t.group = $urandom();
      t.policy_class = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      t.now = ($urandom_range(0, 15) == 0) ? $urandom() : clock_now;
      send_paced(t);
    end
  endtask

  initial begin
    error_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PROFILE;
    cfg_data = '0;
    model_profile = 1'b0;
    model_qi = 16'd10;
    for (int i = 0; i < NumEntries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_group[i] = '0;
      tbl_time[i] = '0;
      tbl_pinned[i] = 1'b0;
      tbl_grey[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) group_pool[i] = $urandom();
    group_pool[0] = 32'h0;
    group_pool[1] = 32'hFFFF_FFFF;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_no_profile();
    wait_idle();
    write_register(CFG_PROFILE, 16'h0001);
    test_directed_ops();
    test_table_full();
    wait_idle();
    write_register(CFG_INTERVAL, 16'd1);
    test_random(70, 32'hFFFF_FF00);
    test_backpressure();
    wait_idle();
    write_register(CFG_INTERVAL, 16'hFFFF);
    test_random(70, 32'd0);
    wait_idle();
    write_register(CFG_PROFILE, 16'hFFFE);
    test_random(30, 32'd500);
    wait_idle();
    write_register(CFG_PROFILE, 16'h0001);
    write_register(CFG_INTERVAL, 16'd10);
    test_random(110, 32'h8000_0000);

    wait_idle();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mmt_pkg.sv
sv/mmt_cell.sv
sv/multicast_membership_table_unit.sv
sv/mmt_checker.sv
dv/multicast_membership_table_unit_tb.sv
